FILE: rtl/core/itt_pkg.sv
// Shared types, character codes and character-class functions for the token tracker.
`default_nettype none

package itt_pkg;

   // Width and ceiling of the decimal digit sum.
   localparam int unsigned SUM_W = 16;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // Lexer state codes as shown on the result channel.
   localparam logic [1:0] LEX_GAP  = 2'd0;
   localparam logic [1:0] LEX_NUM  = 2'd1;
   localparam logic [1:0] LEX_WORD = 2'd2;

   // Character codes.
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_Z   = 8'h7a;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_Z    = 8'h5a;
   localparam logic [7:0] CH_UNDER   = 8'h5f;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;

   // Scanner state, one-hot.
   typedef enum logic [2:0] {
      MODE_GAP  = 3'b001,
      MODE_NUM  = 3'b010,
      MODE_WORD = 3'b100
   } mode_type;

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z))
         || (c == CH_UNDER) || (c == CH_MINUS);
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_NEWLINE);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/integer_token_tracker_top.sv
// Top level of the token tracker: byte lexer and last-two-numbers tracker.
`default_nettype none

// Channel   Dir  Payload                                    Handshake
// req_      in   tdata[7:0] = symbol                        tvalid/tready
// rsp_      out  tdata = answer_number, answer_sum, zeros    tvalid/tready
//                tuser = answer_valid, lexer_state
//
// One word is accepted per cycle while req_tready is high; its byte lands in the input
// register, and the next advance loads the result register with the lexer update.
// The multiply-by-ten with saturation sits between those two registers.
// Reset clears the lexer and both stored numbers; payload registers are not reset.
// With rsp_tready low the result holds, and req_tready drops once the input
// register is also full.
module integer_token_tracker_top #(
   parameter int unsigned NUMBER_WIDTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] symbol
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // [NUMBER_WIDTH-1:0] answer_number, then 16 bits answer_sum, zero fill to bytes
   output logic [((NUMBER_WIDTH + itt_pkg::SUM_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [2:0] rsp_tuser          // [0] answer_valid, [2:1] lexer_state
);

   localparam int unsigned SW         = itt_pkg::SUM_W;
   localparam int unsigned MAG_W      = NUMBER_WIDTH - 1;
   localparam int unsigned PROD_W     = MAG_W + 4;
   localparam int unsigned RSP_DATA_W = ((NUMBER_WIDTH + SW + 7) / 8) * 8;
   localparam logic [MAG_W-1:0] MAG_MAX = '1;

   // Input stage.
   logic       in_vld_ff;
   logic [7:0] sym_ff;
   logic       advance;

   // Lexer state.
   itt_pkg::mode_type mode_ff, mode_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [SW-1:0]           dsum_ff, dsum_in;
   logic                    neg_ff, neg_in;
   logic [NUMBER_WIDTH-1:0] last_ff, last_in, older_ff, older_in;
   logic [SW-1:0]           last_sum_ff, last_sum_in, older_sum_ff, older_sum_in;
   logic [1:0]              cnt_ff, cnt_in;

   // Result register.
   logic                  out_vld_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic [2:0]            out_user_ff, out_user_in;

   // Datapath helpers.
   logic [3:0]              digit;
   logic [PROD_W-1:0]       prod;
   logic [MAG_W-1:0]        mag_next;
   logic [SW:0]             sum_ext;
   logic [SW-1:0]           dsum_next;
   logic [NUMBER_WIDTH-1:0] commit_val;
   logic [NUMBER_WIDTH-1:0] ans_num;
   logic [SW-1:0]           ans_sum;
   logic                    ans_vld;
   logic [1:0]              lex_code;

   // Pipeline moves when the result register is empty or being drained.
   assign advance    = ~out_vld_ff | rsp_tready;
   assign req_tready = ~in_vld_ff | advance;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // Digit accumulate: x*10 + d by shifts, saturating at the magnitude ceiling.
   assign digit   = sym_ff[3:0];
   assign prod    = (PROD_W'(mag_ff) << 3) + (PROD_W'(mag_ff) << 1) + PROD_W'(digit);
   assign mag_next = (prod > PROD_W'(MAG_MAX)) ? MAG_MAX : prod[MAG_W-1:0];
   assign sum_ext  = {1'b0, dsum_ff} + (SW + 1)'(digit);
   assign dsum_next = sum_ext[SW] ? itt_pkg::SUM_MAX : sum_ext[SW-1:0];
   assign commit_val = neg_ff ? (NUMBER_WIDTH'(0) - {1'b0, mag_ff}) : {1'b0, mag_ff};

   // Lexer next state.
   always_comb begin
      mode_in      = mode_ff;
      mag_in       = mag_ff;
      dsum_in      = dsum_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      last_sum_in  = last_sum_ff;
      older_in     = older_ff;
      older_sum_in = older_sum_ff;
      cnt_in       = cnt_ff;
      unique case (mode_ff)
         itt_pkg::MODE_GAP: begin
            priority if (sym_ff == itt_pkg::CH_MINUS) begin
               neg_in = 1'b1;
            end else if (itt_pkg::is_dec(sym_ff)) begin
               mag_in  = mag_next;
               dsum_in = dsum_next;
               mode_in = itt_pkg::MODE_NUM;
            end else if (itt_pkg::is_word(sym_ff)) begin
               mode_in = itt_pkg::MODE_WORD;
            end else begin
               // Any other byte leaves the state as it is.
            end
         end
         itt_pkg::MODE_NUM: begin
            priority if (itt_pkg::is_dec(sym_ff)) begin
               mag_in  = mag_next;
               dsum_in = dsum_next;
            end else if (itt_pkg::is_sep(sym_ff)) begin
               // Commit: shift the open number into the two-entry history.
               older_in     = last_ff;
               older_sum_in = last_sum_ff;
               last_in      = commit_val;
               last_sum_in  = dsum_ff;
               if (cnt_ff != 2'd2) begin
                  cnt_in = cnt_ff + 2'd1;
               end
               neg_in  = 1'b0;
               mag_in  = '0;
               dsum_in = '0;
               mode_in = itt_pkg::MODE_GAP;
            end else if (itt_pkg::is_word(sym_ff)) begin
               // The number turns into a word and is dropped.
               mag_in  = '0;
               dsum_in = '0;
               mode_in = itt_pkg::MODE_WORD;
            end else begin
               // Any other byte leaves the open number untouched.
            end
         end
         itt_pkg::MODE_WORD: begin
            if (itt_pkg::is_sep(sym_ff)) begin
               mode_in = itt_pkg::MODE_GAP;
            end
         end
         default: begin
            mode_in = itt_pkg::MODE_GAP;
         end
      endcase
   end

   // Answer: the last number while one is open, otherwise the one before it.
   always_comb begin
      ans_num  = '0;
      ans_sum  = '0;
      ans_vld  = 1'b0;
      lex_code = itt_pkg::LEX_GAP;
      if (mode_in == itt_pkg::MODE_NUM) begin
         lex_code = itt_pkg::LEX_NUM;
         if (cnt_in != 2'd0) begin
            ans_num = last_in;
            ans_sum = last_sum_in;
            ans_vld = 1'b1;
         end
      end else begin
         if (mode_in == itt_pkg::MODE_WORD) begin
            lex_code = itt_pkg::LEX_WORD;
         end
         if (cnt_in == 2'd2) begin
            ans_num = older_in;
            ans_sum = older_sum_in;
            ans_vld = 1'b1;
         end
      end
      out_data_in = '0;
      out_data_in[NUMBER_WIDTH-1:0] = ans_num;
      out_data_in[NUMBER_WIDTH +: SW] = ans_sum;
      out_user_in = {lex_code, ans_vld};
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         mode_ff      <= itt_pkg::MODE_GAP;
         mag_ff       <= '0;
         dsum_ff      <= '0;
         neg_ff       <= 1'b0;
         last_ff      <= '0;
         last_sum_ff  <= '0;
         older_ff     <= '0;
         older_sum_ff <= '0;
         cnt_ff       <= '0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (advance) begin
            out_vld_ff <= in_vld_ff;
         end
         if (advance && in_vld_ff) begin
            mode_ff      <= mode_in;
            mag_ff       <= mag_in;
            dsum_ff      <= dsum_in;
            neg_ff       <= neg_in;
            last_ff      <= last_in;
            last_sum_ff  <= last_sum_in;
            older_ff     <= older_in;
            older_sum_ff <= older_sum_in;
            cnt_ff       <= cnt_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         sym_ff <= req_tdata;
      end
      if (advance && in_vld_ff) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

   // The commit count saturates at two.
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("commit count out of range");

   // Outside a number the accumulators are clear.
   assert property (@(posedge clock) disable iff (reset)
      mode_ff != itt_pkg::MODE_NUM |-> (mag_ff == '0) && (dsum_ff == '0))
      else $error("accumulator not cleared outside a number");

   // A result without enough numbers carries zero data.
   assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !out_user_ff[0] |-> out_data_ff == '0)
      else $error("answer data nonzero while answer not valid");

   // Reported lexer state is a legal code.
   assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> out_user_ff[2:1] != 2'b11)
      else $error("illegal lexer state code");

   // An item in the input register moves on when the result side drains.
   assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && advance |=> out_vld_ff)
      else $error("item lost between input and result registers");

endmodule

`default_nettype wire
